// ===== sv/ttbo_pkg.sv =====
// Shared types, codes and stage payloads for the tiled texel byte offset block.
package ttbo_pkg;

  localparam int CoordW  = 14;
  localparam int PadW    = 16;
  localparam int OffW    = 32;
  localparam int GroupW  = 9;   // x / 32
  localparam int IdW     = 24;  // id * 256 wraps at 32 bits
  localparam int AddendW = 14;
  localparam int LinW    = 20;
  localparam int SubW    = 8;
  localparam int IdxW    = 3;

  // Tiling codes
  localparam logic [2:0] TILE_LINEAR  = 3'd0;
  localparam logic [2:0] TILE_UBL1    = 3'd1;
  localparam logic [2:0] TILE_UBL2    = 3'd2;
  localparam logic [2:0] TILE_UIF     = 3'd3;
  localparam logic [2:0] TILE_UIF_XOR = 3'd4;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_TILING_MODE    = 3'd0;
  localparam logic [IdxW-1:0] REG_LOGICAL_WIDTH  = 3'd1;
  localparam logic [IdxW-1:0] REG_LOGICAL_HEIGHT = 3'd2;
  localparam logic [IdxW-1:0] REG_ALIGNED_WIDTH  = 3'd3;
  localparam logic [IdxW-1:0] REG_ALIGNED_HEIGHT = 3'd4;
  localparam logic [IdxW-1:0] REG_TOTAL_BYTES    = 3'd5;

  typedef struct packed {
    logic [2:0]        tiling_mode;
    logic [CoordW-1:0] logical_width;
    logic [CoordW-1:0] logical_height;
    logic [PadW-1:0]   aligned_width;
    logic [PadW-1:0]   aligned_height;
    logic [OffW-1:0]   total_bytes;
  } cfg_t;

  // After decode
  typedef struct packed {
    logic               bad;
    logic               is_lin;
    logic [LinW-1:0]    lin_off;
    logic [GroupW-1:0]  group;
    logic [IdW-1:0]     row_term;
    logic [AddendW-1:0] addend;
    logic [SubW-1:0]    sub;
  } dec_t;

  // After the group multiply
  typedef struct packed {
    logic               bad;
    logic               is_lin;
    logic [LinW-1:0]    lin_off;
    logic [IdW-1:0]     prod;
    logic [AddendW-1:0] addend;
    logic [SubW-1:0]    sub;
  } mul_t;

  // After the offset sum
  typedef struct packed {
    logic            bad;
    logic [OffW-1:0] off;
  } sum_t;

endpackage

// ===== sv/ttbo_req_if.sv =====
// Request channel: texel coordinate word.
interface ttbo_req_if import ttbo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] texel_x;
  logic [CoordW-1:0] texel_y;

  modport source (output valid, texel_x, texel_y, input ready);
  modport sink (input valid, texel_x, texel_y, output ready);
endinterface

// ===== sv/ttbo_rsp_if.sv =====
// Response channel: byte offset word with its valid flag.
interface ttbo_rsp_if import ttbo_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OffW-1:0] byte_offset;
  logic            valid_res;

  modport source (output valid, byte_offset, valid_res, input ready);
  modport sink (input valid, byte_offset, valid_res, output ready);
endinterface

// ===== sv/ttbo_decode.sv =====
// Stage 1: range checks, tiling decode and operand preparation.
module ttbo_decode import ttbo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CoordW-1:0] texel_x,
  input  logic [CoordW-1:0] texel_y,
  output logic              out_valid,
  input  logic              out_ready,
  output dec_t              out_data
);

  logic              valid_q;
  dec_t              data_q;
  dec_t              dec_next;
  logic [11:0]       ux, uy;
  logic [10:0]       bx, by, by_sw;
  logic [12:0]       rows;
  logic [SubW-1:0]   in_utile;
  logic              is_uif, bad_layout;

  always_comb begin
    ux       = texel_x[13:2];
    uy       = texel_y[13:2];
    bx       = texel_x[13:3];
    by       = texel_y[13:3];
    rows     = cfg.aligned_height[15:3];
    in_utile = {2'b00, texel_y[1:0], texel_x[1:0], 2'b00};
    is_uif   = (cfg.tiling_mode == TILE_UIF) || (cfg.tiling_mode == TILE_UIF_XOR);

    // XOR swizzle on odd column groups
    by_sw = by;
    if (cfg.tiling_mode == TILE_UIF_XOR && bx[2]) begin
      by_sw = by ^ 11'h010;
    end

    bad_layout = (texel_x >= cfg.logical_width) || (texel_y >= cfg.logical_height) ||
                 (cfg.aligned_width < {2'b00, cfg.logical_width}) ||
                 (cfg.aligned_height < {2'b00, cfg.logical_height}) ||
                 (cfg.total_bytes == '0);

    dec_next.is_lin   = 1'b0;
    dec_next.lin_off  = '0;
    dec_next.group    = '0;
    dec_next.row_term = '0;
    dec_next.addend   = '0;
    dec_next.sub      = {texel_y[2], texel_x[2], 6'd0} | in_utile;
    dec_next.bad      = bad_layout;

    case (cfg.tiling_mode)
      TILE_LINEAR: begin
        dec_next.is_lin  = 1'b1;
        dec_next.lin_off = {({1'b0, ux} + {1'b0, uy}), 6'd0} + {12'd0, in_utile};
        if (ux != '0 && uy != '0) begin
          dec_next.bad = 1'b1;
        end
      end
      TILE_UBL1: begin
        dec_next.addend = {3'd0, by} + {3'd0, bx};
      end
      TILE_UBL2: begin
        dec_next.addend = {2'd0, by, 1'b0} + {3'd0, bx};
      end
      TILE_UIF, TILE_UIF_XOR: begin
        dec_next.group    = bx[10:2];
        dec_next.row_term = ({11'd0, rows} - 24'd1) << 2;
        dec_next.addend   = {1'b0, by_sw, 2'b00} + {3'd0, bx};
      end
      default: begin
        dec_next.bad = 1'b1;
      end
    endcase
    if (!is_uif) begin
      dec_next.group = '0;
    end
  end

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_data  = data_q;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_q <= dec_next;
    end
  end

endmodule

// ===== sv/ttbo_mult.sv =====
// Stage 2: column group times the group stride.
module ttbo_mult import ttbo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  dec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output mul_t out_data
);

  logic                     valid_q;
  mul_t                     data_q;
  mul_t                     mul_next;
  logic [IdW+GroupW-1:0]    prod_full;

  always_comb begin
    prod_full        = {{GroupW{1'b0}}, in_data.row_term} *
                       {{IdW{1'b0}}, in_data.group};
    mul_next.bad     = in_data.bad;
    mul_next.is_lin  = in_data.is_lin;
    mul_next.lin_off = in_data.lin_off;
    mul_next.prod    = prod_full[IdW-1:0];
    mul_next.addend  = in_data.addend;
    mul_next.sub     = in_data.sub;
  end

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_data  = data_q;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_q <= mul_next;
    end
  end

endmodule

// ===== sv/ttbo_sum.sv =====
// Stage 3: block id and byte offset.
module ttbo_sum import ttbo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mul_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sum_t out_data
);

  logic           valid_q;
  sum_t           data_q;
  sum_t           sum_next;
  logic [IdW-1:0] id;

  always_comb begin
    id           = in_data.prod + {{(IdW-AddendW){1'b0}}, in_data.addend};
    sum_next.bad = in_data.bad;
    // sub-block offset stays under 256, so it fills the low byte
    sum_next.off = in_data.is_lin ? {{(OffW-LinW){1'b0}}, in_data.lin_off}
                                  : {id, in_data.sub};
  end

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_data  = data_q;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_q <= sum_next;
    end
  end

endmodule

// ===== sv/ttbo_bound.sv =====
// Stage 4: bounds check against the texture size; output register.
module ttbo_bound import ttbo_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [OffW-1:0] total_bytes,
  input  logic            in_valid,
  output logic            in_ready,
  input  sum_t            in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OffW-1:0] byte_offset,
  output logic            valid_res
);

  logic            valid_q;
  logic [OffW-1:0] off_q;
  logic            ok_q;
  logic            ok;
  logic [OffW-1:0] limit;

  // limit wraps for sizes below four
  assign limit = total_bytes - 32'd4;
  assign ok    = !in_data.bad && (in_data.off <= limit);

  assign in_ready    = !valid_q || out_ready;
  assign out_valid   = valid_q;
  assign byte_offset = off_q;
  assign valid_res   = ok_q;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ok_q  <= ok;
      off_q <= ok ? in_data.off : '0;
    end
  end

endmodule

// ===== sv/tiled_texel_byte_offset.sv =====
// Top level of the tiled texel byte offset unit.
//
// Turns a texel coordinate word on req into the byte offset of that texel in
// an RGBA8 texture laid out as linear microtiles, one- or two-column block
// linear, or UIF with or without the XOR swizzle. Each rsp word carries
// byte_offset and valid_res; an out-of-range coordinate, bad layout, unknown
// tiling or an offset past total_bytes - 4 gives valid_res 0 and offset 0.
// Layout registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the unit is idle, which the block itself
// does not enforce. Indexes past the register list are ignored. Each word
// passes four registered stages: decode, group multiply (9 x 24 bit), offset
// sum, bounds check into the output register.
// Throughput is one word per cycle while rsp takes words; each stage holds
// one word and moves on when the stage ahead is empty or advancing.
// When rsp stalls, words stay in place and req keeps taking words until all
// four stages are full; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and clears all layout registers.
module tiled_texel_byte_offset import ttbo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [OffW-1:0]   cfg_data,
  ttbo_req_if.sink          req,
  ttbo_rsp_if.source        rsp
);

  cfg_t cfg;
  logic d_valid, d_ready, m_valid, m_ready, s_valid, s_ready;
  dec_t d_data;
  mul_t m_data;
  sum_t s_data;

  // Layout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILING_MODE:    cfg.tiling_mode    <= cfg_data[2:0];
        REG_LOGICAL_WIDTH:  cfg.logical_width  <= cfg_data[CoordW-1:0];
        REG_LOGICAL_HEIGHT: cfg.logical_height <= cfg_data[CoordW-1:0];
        REG_ALIGNED_WIDTH:  cfg.aligned_width  <= cfg_data[PadW-1:0];
        REG_ALIGNED_HEIGHT: cfg.aligned_height <= cfg_data[PadW-1:0];
        REG_TOTAL_BYTES:    cfg.total_bytes    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ttbo_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .texel_x   (req.texel_x),
    .texel_y   (req.texel_y),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  ttbo_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_data  (m_data)
  );

  ttbo_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_data   (m_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  ttbo_bound u_bound (
    .clk         (clk),
    .rst         (rst),
    .total_bytes (cfg.total_bytes),
    .in_valid    (s_valid),
    .in_ready    (s_ready),
    .in_data     (s_data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .byte_offset (rsp.byte_offset),
    .valid_res   (rsp.valid_res)
  );

  // Checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("rsp valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.valid_res |-> rsp.byte_offset == '0)
    else $error("rejected word carries nonzero offset");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.valid_res |-> rsp.byte_offset[1:0] == 2'b00)
    else $error("texel offset not word aligned");

endmodule
